### rtl/xes_pkg.sv
package xes_pkg;

	localparam int SLOTS_DEF = 256;
	localparam int SN_W      = 10;
	localparam int HW_OUT_W  = 9;
	// wide enough for any slot number, slot count or high-water mark
	localparam int CMP_W     = 11;

	// command codes
	localparam logic [2:0] CMD_CLEAR    = 3'd0;
	localparam logic [2:0] CMD_INSERT   = 3'd1;
	localparam logic [2:0] CMD_SET_XMAX = 3'd2;
	localparam logic [2:0] CMD_REDO     = 3'd3;
	localparam logic [2:0] CMD_INTERP   = 3'd4;

	// slot flag bits
	localparam int FLAG_XMIN_BIT = 0;
	localparam int FLAG_XMAX_BIT = 1;

	// xmin mode codes
	localparam logic [1:0] XMIN_MAT      = 2'd0;
	localparam logic [1:0] XMIN_IMPLICIT = 2'd1;
	localparam logic [1:0] XMIN_FROZEN   = 2'd2;
	localparam logic [1:0] XMIN_INVALID  = 2'd3;

	// xmax mode codes
	localparam logic [2:0] XMAX_MAT      = 3'd0;
	localparam logic [2:0] XMAX_IMPLICIT = 3'd1;
	localparam logic [2:0] XMAX_INVALID  = 3'd2;
	localparam logic [2:0] XMAX_UNSET    = 3'd3;
	localparam logic [2:0] XMAX_MULTI    = 3'd4;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} ctrl_t;

	typedef struct packed {
		logic [31:0] xmin_ep;
		logic [31:0] xmax_ep;
		logic [1:0]  flags;
	} slot_t;

endpackage

### rtl/xes_ctrl.sv
module xes_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output xes_pkg::ctrl_t    ctl
);

	xes_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xes_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			xes_pkg::ST_IDLE: begin
				if (start) state_nx = xes_pkg::ST_EXEC;
			end
			xes_pkg::ST_EXEC: begin
				state_nx = xes_pkg::ST_IDLE;
			end
			default: state_nx = xes_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		ctl.capture = 1'b0;
		ctl.exec    = 1'b0;
		unique case (state_q)
			xes_pkg::ST_IDLE: begin
				ctl.capture = start;
			end
			xes_pkg::ST_EXEC: begin
				busy     = 1'b1;
				ctl.exec = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

### rtl/xes_dp.sv
module xes_dp #(
	parameter int SLOTS = xes_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  xes_pkg::ctrl_t                ctl,
	input  logic                          cfg_we,
	input  logic [31:0]                   cfg_wdata,
	input  logic [2:0]                    command,
	input  logic [xes_pkg::SN_W-1:0]      slot_number,
	input  logic [31:0]                   xmin_epoch_in,
	input  logic [31:0]                   xmax_epoch_in,
	input  logic [1:0]                    flags_in,
	input  logic                          whole_reset,
	input  logic [31:0]                   raw_xmin,
	input  logic [31:0]                   raw_xmax,
	input  logic                          xmin_frozen,
	input  logic                          xmax_invalid,
	input  logic                          xmax_multi,
	input  logic                          materialized,
	output logic                          done,
	output logic [63:0]                   xmin_wide,
	output logic [63:0]                   xmax_wide,
	output logic [1:0]                    xmin_mode,
	output logic [2:0]                    xmax_mode,
	output logic                          range_error,
	output logic [xes_pkg::HW_OUT_W-1:0]  high_water
);

	localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HWW = $clog2(SLOTS + 1);

	xes_pkg::slot_t mem [SLOTS];
	xes_pkg::slot_t rd_s1, cur, wdata;
	logic           vld_s1;
	logic [SLOTS-1:0] vld_q;

	logic [31:0]    def_epoch_q;
	logic [HWW-1:0] hw_q;

	// captured command word
	logic [2:0]               cmd_q;
	logic [xes_pkg::SN_W-1:0] sn_q;
	logic [IW-1:0]            idx_q;
	logic                     in_range_q;
	logic [31:0]              xmin_ep_q, xmax_ep_q, rxmin_q, rxmax_q;
	logic [1:0]               fl_q;
	logic                     whole_q, frozen_q, xinv_q, multi_q, mat_q;

	logic          in_range;
	logic [IW-1:0] rd_idx;
	logic          is_write, we, present;
	logic [1:0]    sf;

	logic [63:0] fxmin, fxmax;
	logic [1:0]  mmin;
	logic [2:0]  mmax;
	logic        rerr;

	assign in_range = (slot_number != '0) &&
		(xes_pkg::CMP_W'(slot_number) <= xes_pkg::CMP_W'(SLOTS));
	assign rd_idx   = in_range ? IW'(slot_number - xes_pkg::SN_W'(1)) : '0;

	// slot memory, registered read at capture, write during execute
	always_ff @(posedge clk) begin
		if (we) mem[idx_q] <= wdata;
		if (ctl.capture) begin
			rd_s1      <= mem[rd_idx];
			vld_s1     <= vld_q[rd_idx];
			cmd_q      <= command;
			sn_q       <= slot_number;
			idx_q      <= rd_idx;
			in_range_q <= in_range;
			xmin_ep_q  <= xmin_epoch_in;
			xmax_ep_q  <= xmax_epoch_in;
			fl_q       <= flags_in;
			whole_q    <= whole_reset;
			rxmin_q    <= raw_xmin;
			rxmax_q    <= raw_xmax;
			frozen_q   <= xmin_frozen;
			xinv_q     <= xmax_invalid;
			multi_q    <= xmax_multi;
			mat_q      <= materialized;
		end
	end

	// entries not written since the last clear read as zero
	assign cur = vld_s1 ? rd_s1 : '0;

	always_comb begin
		is_write = 1'b0;
		wdata    = cur;
		case (cmd_q) inside
			xes_pkg::CMD_INSERT: begin
				is_write      = 1'b1;
				wdata.xmin_ep = xmin_ep_q;
				wdata.xmax_ep = '0;
				wdata.flags   = '0;
				wdata.flags[xes_pkg::FLAG_XMIN_BIT] = 1'b1;
			end
			xes_pkg::CMD_SET_XMAX: begin
				is_write      = 1'b1;
				wdata.xmax_ep = xmax_ep_q;
				wdata.flags[xes_pkg::FLAG_XMAX_BIT] = 1'b1;
			end
			xes_pkg::CMD_REDO: begin
				is_write = 1'b1;
				if (whole_q) begin
					wdata.xmin_ep = xmin_ep_q;
					wdata.xmax_ep = xmax_ep_q;
					wdata.flags   = fl_q;
				end else begin
					if (fl_q[xes_pkg::FLAG_XMIN_BIT]) wdata.xmin_ep = xmin_ep_q;
					if (fl_q[xes_pkg::FLAG_XMAX_BIT]) wdata.xmax_ep = xmax_ep_q;
					wdata.flags = cur.flags | fl_q;
				end
			end
			default: ;
		endcase
	end

	assign we   = ctl.exec && is_write && in_range_q;
	assign rerr = is_write && !in_range_q;

	assign present = mat_q && in_range_q &&
		(xes_pkg::CMP_W'(sn_q) <= xes_pkg::CMP_W'(hw_q));
	assign sf = present ? cur.flags : 2'b00;

	always_comb begin
		fxmin = '0;
		fxmax = '0;
		mmin  = xes_pkg::XMIN_MAT;
		mmax  = xes_pkg::XMAX_MAT;
		if (cmd_q == xes_pkg::CMD_INTERP) begin
			if (frozen_q) begin
				fxmin = 64'd2;
				mmin  = xes_pkg::XMIN_FROZEN;
			end else if (rxmin_q == '0) begin
				mmin  = xes_pkg::XMIN_INVALID;
			end else if (sf[xes_pkg::FLAG_XMIN_BIT]) begin
				fxmin = {cur.xmin_ep, rxmin_q};
			end else begin
				fxmin = {def_epoch_q, rxmin_q};
				mmin  = xes_pkg::XMIN_IMPLICIT;
			end

			if (xinv_q) begin
				mmax  = xes_pkg::XMAX_UNSET;
			end else if (multi_q) begin
				mmax  = xes_pkg::XMAX_MULTI;
			end else if (rxmax_q == '0) begin
				mmax  = xes_pkg::XMAX_INVALID;
			end else if (sf[xes_pkg::FLAG_XMAX_BIT]) begin
				fxmax = {cur.xmax_ep, rxmax_q};
			end else begin
				fxmax = {def_epoch_q, rxmax_q};
				mmax  = xes_pkg::XMAX_IMPLICIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_epoch_q <= '0;
			hw_q        <= '0;
			vld_q       <= '0;
			done        <= 1'b0;
		end else begin
			done <= ctl.exec;
			if (cfg_we) def_epoch_q <= cfg_wdata;
			if (ctl.exec && cmd_q == xes_pkg::CMD_CLEAR) begin
				vld_q <= '0;
				hw_q  <= '0;
			end else if (we) begin
				vld_q[idx_q] <= 1'b1;
				if (xes_pkg::CMP_W'(sn_q) > xes_pkg::CMP_W'(hw_q)) hw_q <= HWW'(sn_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			xmin_wide   <= fxmin;
			xmax_wide   <= fxmax;
			xmin_mode   <= mmin;
			xmax_mode   <= mmax;
			range_error <= rerr;
		end
	end

	assign high_water = xes_pkg::HW_OUT_W'(hw_q);

endmodule

### rtl/xid_epoch_slot_table.sv
// the word is captured at the start edge; result and done are registered at the end of the execute cycle
// a new word is taken only while busy is low; busy is high only for the execute cycle after start
// slot read registered at the start edge, write-back at the end of the execute cycle
// the receiver cannot stall: done is high for exactly one cycle per word
// reset clears control state, default epoch, high-water mark and slot valid bits,
// so every slot reads as zero at once, with no clearing pass
module xid_epoch_slot_table #(
	parameter int SLOTS = xes_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command handshake
	input  logic                          start,
	output logic                          busy,
	// default epoch register
	input  logic                          cfg_we,
	input  logic [31:0]                   cfg_wdata,
	// command word
	input  logic [2:0]                    command,
	input  logic [xes_pkg::SN_W-1:0]      slot_number,
	input  logic [31:0]                   xmin_epoch_in,
	input  logic [31:0]                   xmax_epoch_in,
	input  logic [1:0]                    flags_in,
	input  logic                          whole_reset,
	input  logic [31:0]                   raw_xmin,
	input  logic [31:0]                   raw_xmax,
	input  logic                          xmin_frozen,
	input  logic                          xmax_invalid,
	input  logic                          xmax_multi,
	input  logic                          materialized,
	// result word
	output logic                          done,
	output logic [63:0]                   xmin_wide,
	output logic [63:0]                   xmax_wide,
	output logic [1:0]                    xmin_mode,
	output logic [2:0]                    xmax_mode,
	output logic                          range_error,
	output logic [xes_pkg::HW_OUT_W-1:0]  high_water
);

	// capture / execute strobes from the sequencer
	xes_pkg::ctrl_t ctl;

	// two-state sequencer: idle, then an execute state for each word
	xes_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl)
	);

	// slot memory, high-water mark, merge and interpret logic
	xes_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.command       (command),
		.slot_number   (slot_number),
		.xmin_epoch_in (xmin_epoch_in),
		.xmax_epoch_in (xmax_epoch_in),
		.flags_in      (flags_in),
		.whole_reset   (whole_reset),
		.raw_xmin      (raw_xmin),
		.raw_xmax      (raw_xmax),
		.xmin_frozen   (xmin_frozen),
		.xmax_invalid  (xmax_invalid),
		.xmax_multi    (xmax_multi),
		.materialized  (materialized),
		.done          (done),
		.xmin_wide     (xmin_wide),
		.xmax_wide     (xmax_wide),
		.xmin_mode     (xmin_mode),
		.xmax_mode     (xmax_mode),
		.range_error   (range_error),
		.high_water    (high_water)
	);

`ifndef SYNTHESIS
	// an accepted word occupies the block for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// the execute cycle always produces exactly one result word
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("execute cycle did not deliver a result");

	// results only follow an execute cycle
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without execute cycle");

	// a range error never carries interpret results
	a_rerr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && range_error) |-> (xmin_wide == '0 && xmax_wide == '0))
		else $error("range error with nonzero interpret output");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import xes_pkg::*;

	localparam int SLOTS = SLOTS_DEF;
	// generous bound for the watchdog
	localparam int CYCLE_LIMIT = 60000;
	localparam int WORDS_PER_PHASE = 217;

	// spare command codes, the block must leave its state alone on these
	localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

	// one command word as it goes to the block
	typedef struct {
		logic [2:0]      command;
		logic [SN_W-1:0] slot_number;
		logic [31:0]     xmin_ep;
		logic [31:0]     xmax_ep;
		logic [1:0]      flags;
		logic            whole;
		logic [31:0]     raw_xmin;
		logic [31:0]     raw_xmax;
		logic            frozen;
		logic            xinv;
		logic            multi;
		logic            mat;
	} word_t;

	// one result word as it comes back on done
	typedef struct {
		logic [63:0]         xmin_wide;
		logic [63:0]         xmax_wide;
		logic [1:0]          xmin_mode;
		logic [2:0]          xmax_mode;
		logic                range_err;
		logic [HW_OUT_W-1:0] high_water;
	} result_t;

	// directed row: the word and, where it is obvious, its result typed in by hand
	typedef struct {
		word_t   w;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                cfg_we;
	logic [31:0]         cfg_wdata;
	logic [2:0]          command;
	logic [SN_W-1:0]     slot_number;
	logic [31:0]         xmin_epoch_in;
	logic [31:0]         xmax_epoch_in;
	logic [1:0]          flags_in;
	logic                whole_reset;
	logic [31:0]         raw_xmin;
	logic [31:0]         raw_xmax;
	logic                xmin_frozen;
	logic                xmax_invalid;
	logic                xmax_multi;
	logic                materialized;
	logic                done;
	logic [63:0]         xmin_wide;
	logic [63:0]         xmax_wide;
	logic [1:0]          xmin_mode;
	logic [2:0]          xmax_mode;
	logic                range_error;
	logic [HW_OUT_W-1:0] high_water;

	xid_epoch_slot_table #(
		.SLOTS(SLOTS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.command       (command),
		.slot_number   (slot_number),
		.xmin_epoch_in (xmin_epoch_in),
		.xmax_epoch_in (xmax_epoch_in),
		.flags_in      (flags_in),
		.whole_reset   (whole_reset),
		.raw_xmin      (raw_xmin),
		.raw_xmax      (raw_xmax),
		.xmin_frozen   (xmin_frozen),
		.xmax_invalid  (xmax_invalid),
		.xmax_multi    (xmax_multi),
		.materialized  (materialized),
		.done          (done),
		.xmin_wide     (xmin_wide),
		.xmax_wide     (xmax_wide),
		.xmin_mode     (xmin_mode),
		.xmax_mode     (xmax_mode),
		.range_error   (range_error),
		.high_water    (high_water)
	);

	// shadow copy of the page: slot epochs, slot flags, high-water mark, default epoch
	logic [31:0] shadow_xmin_ep [SLOTS];
	logic [31:0] shadow_xmax_ep [SLOTS];
	logic [1:0]  shadow_flags   [SLOTS];
	int unsigned shadow_high_water;
	logic [31:0] shadow_default_epoch;

	// results owed by the block, oldest first
	result_t owed_results [$];

	int cycles;
	int mismatches;
	int results_checked;
	int words_sent;
	int cmd_seen [8];
	int range_errs_seen;
	int slot_hits;
	int epoch_settings;
	int idle_pct;

	// free-running clock, 4 ns period
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// predicts one command word and moves the shadow page along with it
	function automatic result_t epoch_table_apply(input word_t w);
		result_t     r;
		logic        in_range;
		int unsigned ix;
		logic        present;
		logic [1:0]  sf;
		r = '{default: '0};
		in_range = (w.slot_number >= 1) && (w.slot_number <= SLOTS);
		ix = in_range ? w.slot_number - 1 : 0;
		case (w.command)
			CMD_CLEAR: begin
				for (int i = 0; i < SLOTS; i++) begin
					shadow_xmin_ep[i] = '0;
					shadow_xmax_ep[i] = '0;
					shadow_flags[i] = '0;
				end
				shadow_high_water = 0;
			end
			CMD_INSERT, CMD_SET_XMAX, CMD_REDO: begin
				if (!in_range) begin
					r.range_err = 1'b1;
				end else begin
					if (w.command == CMD_INSERT) begin
						shadow_xmin_ep[ix] = w.xmin_ep;
						shadow_xmax_ep[ix] = '0;
						shadow_flags[ix] = 2'b00;
						shadow_flags[ix][FLAG_XMIN_BIT] = 1'b1;
					end else if (w.command == CMD_SET_XMAX) begin
						shadow_xmax_ep[ix] = w.xmax_ep;
						shadow_flags[ix][FLAG_XMAX_BIT] = 1'b1;
					end else if (w.whole) begin
						shadow_xmin_ep[ix] = w.xmin_ep;
						shadow_xmax_ep[ix] = w.xmax_ep;
						shadow_flags[ix] = w.flags;
					end else begin
						// log merge: only the flagged halves move
						if (w.flags[FLAG_XMIN_BIT])
							shadow_xmin_ep[ix] = w.xmin_ep;
						if (w.flags[FLAG_XMAX_BIT])
							shadow_xmax_ep[ix] = w.xmax_ep;
						shadow_flags[ix] = shadow_flags[ix] | w.flags;
					end
					if (w.slot_number > shadow_high_water)
						shadow_high_water = w.slot_number;
				end
			end
			CMD_INTERP: begin
				// slot is only looked at when materialized, in range and at or under the high-water mark
				present = w.mat && in_range && (w.slot_number <= shadow_high_water);
				sf = present ? shadow_flags[ix] : 2'b00;
				if (present)
					slot_hits++;

				if (w.frozen) begin
					r.xmin_wide = 64'd2;
					r.xmin_mode = XMIN_FROZEN;
				end else if (w.raw_xmin == '0) begin
					r.xmin_mode = XMIN_INVALID;
				end else if (sf[FLAG_XMIN_BIT]) begin
					r.xmin_wide = {shadow_xmin_ep[ix], w.raw_xmin};
					r.xmin_mode = XMIN_MAT;
				end else begin
					r.xmin_wide = {shadow_default_epoch, w.raw_xmin};
					r.xmin_mode = XMIN_IMPLICIT;
				end

				if (w.xinv) begin
					r.xmax_mode = XMAX_UNSET;
				end else if (w.multi) begin
					r.xmax_mode = XMAX_MULTI;
				end else if (w.raw_xmax == '0) begin
					r.xmax_mode = XMAX_INVALID;
				end else if (sf[FLAG_XMAX_BIT]) begin
					r.xmax_wide = {shadow_xmax_ep[ix], w.raw_xmax};
					r.xmax_mode = XMAX_MAT;
				end else begin
					r.xmax_wide = {shadow_default_epoch, w.raw_xmax};
					r.xmax_mode = XMAX_IMPLICIT;
				end
			end
			default: ;
		endcase
		r.high_water = shadow_high_water[HW_OUT_W-1:0];
		return r;
	endfunction

	function automatic word_t mk_word(input logic [2:0] cmd, input logic [SN_W-1:0] sn,
			input logic [31:0] xmin_ep, input logic [31:0] xmax_ep, input logic [1:0] flags,
			input logic whole, input logic [31:0] rxmin, input logic [31:0] rxmax,
			input logic frozen, input logic xinv, input logic multi, input logic mat);
		word_t w;
		w.command = cmd;
		w.slot_number = sn;
		w.xmin_ep = xmin_ep;
		w.xmax_ep = xmax_ep;
		w.flags = flags;
		w.whole = whole;
		w.raw_xmin = rxmin;
		w.raw_xmax = rxmax;
		w.frozen = frozen;
		w.xinv = xinv;
		w.multi = multi;
		w.mat = mat;
		return w;
	endfunction

	function automatic result_t mk_res(input logic [63:0] fxmin, input logic [63:0] fxmax,
			input logic [1:0] mmin, input logic [2:0] mmax, input logic rerr,
			input logic [HW_OUT_W-1:0] hw);
		result_t r;
		r.xmin_wide = fxmin;
		r.xmax_wide = fxmax;
		r.xmin_mode = mmin;
		r.xmax_mode = mmax;
		r.range_err = rerr;
		r.high_water = hw;
		return r;
	endfunction

	function automatic logic [31:0] rand_epoch();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10)
			return '0;
		else if (p < 20)
			return '1;
		return $urandom;
	endfunction

	function automatic logic [31:0] rand_xid();
		int p;
		p = $urandom_range(0, 99);
		if (p < 12)
			return '0;
		else if (p < 18)
			return '1;
		return $urandom;
	endfunction

	// random word: mostly a few low slots so writes and reads meet, some far and bad slots
	function automatic word_t rand_word();
		word_t w;
		int    p;
		p = $urandom_range(0, 99);
		if (p < 3)
			w.command = CMD_CLEAR;
		else if (p < 28)
			w.command = CMD_INSERT;
		else if (p < 43)
			w.command = CMD_SET_XMAX;
		else if (p < 66)
			w.command = CMD_REDO;
		else if (p < 97)
			w.command = CMD_INTERP;
		else
			w.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));

		p = $urandom_range(0, 99);
		if (p < 60)
			w.slot_number = SN_W'($urandom_range(1, 12));
		else if (p < 80)
			w.slot_number = SN_W'($urandom_range(1, SLOTS));
		else if (p < 86)
			w.slot_number = ($urandom_range(0, 1) != 0) ? SN_W'(SLOTS) : SN_W'(1);
		else if (p < 90)
			w.slot_number = '0;
		else if (p < 96)
			w.slot_number = SN_W'($urandom_range(SLOTS + 1, (1 << SN_W) - 1));
		else
			w.slot_number = SN_W'($urandom_range(0, (1 << SN_W) - 1));

		w.xmin_ep = rand_epoch();
		w.xmax_ep = rand_epoch();
		w.flags = 2'($urandom_range(0, 3));
		w.whole = 1'($urandom_range(0, 1));
		w.raw_xmin = rand_xid();
		w.raw_xmax = rand_xid();
		w.frozen = ($urandom_range(0, 99) < 15);
		w.xinv = ($urandom_range(0, 99) < 15);
		w.multi = ($urandom_range(0, 99) < 15);
		w.mat = ($urandom_range(0, 99) < 75);
		return w;
	endfunction

	// puts a word on the ports and holds it until the block takes it
	task automatic send_word(input word_t w, input bit typed, input result_t want);
		result_t r;
		command <= w.command;
		slot_number <= w.slot_number;
		xmin_epoch_in <= w.xmin_ep;
		xmax_epoch_in <= w.xmax_ep;
		flags_in <= w.flags;
		whole_reset <= w.whole;
		raw_xmin <= w.raw_xmin;
		raw_xmax <= w.raw_xmax;
		xmin_frozen <= w.frozen;
		xmax_invalid <= w.xinv;
		xmax_multi <= w.multi;
		materialized <= w.mat;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		// taken at this edge: predict in order of acceptance
		r = epoch_table_apply(w);
		if (typed)
			r = want;
		owed_results.push_back(r);
		words_sent++;
		cmd_seen[w.command]++;
		if (r.range_err)
			range_errs_seen++;
	endtask

	// sender gap after a word, drawn cycle by cycle
	task automatic sender_gap();
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// new default epoch, only with the block drained and quiet
	task automatic write_default_epoch(input logic [31:0] v);
		start <= 1'b0;
		while (owed_results.size() != 0 || busy)
			@(posedge clk);
		// every word has a result, so a short settle is plenty
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_default_epoch = v;
		epoch_settings++;
	endtask

	// result checker: one result per done pulse, no back-pressure possible
	always @(posedge clk) begin
		result_t want;
		bit      bad;
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result word with nothing owed: xmin %h xmax %h hw %0d",
						$time, xmin_wide, xmax_wide, high_water);
			end else begin
				want = owed_results.pop_front();
				results_checked++;
				bad = (xmin_wide !== want.xmin_wide) || (xmax_wide !== want.xmax_wide) ||
					(xmin_mode !== want.xmin_mode) || (xmax_mode !== want.xmax_mode) ||
					(range_error !== want.range_err) || (high_water !== want.high_water);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("[%0t] result mismatch on word %0d", $time, results_checked);
						$display("  xmin_wide   exp %h got %h", want.xmin_wide, xmin_wide);
						$display("  xmax_wide   exp %h got %h", want.xmax_wide, xmax_wide);
						$display("  xmin_mode   exp %0d got %0d", want.xmin_mode, xmin_mode);
						$display("  xmax_mode   exp %0d got %0d", want.xmax_mode, xmax_mode);
						$display("  range_error exp %0d got %0d", want.range_err, range_error);
						$display("  high_water  exp %0d got %0d", want.high_water, high_water);
					end
				end
			end
		end
	end

	// stimulus: directed rows, then three random phases with different sender idling
	initial begin
		dir_row_t dir_rows [$];
		result_t  none;
		logic [31:0] phase_epoch [3];

		none = '{default: '0};
		mismatches = 0;
		results_checked = 0;
		words_sent = 0;
		range_errs_seen = 0;
		slot_hits = 0;
		epoch_settings = 0;
		idle_pct = 0;
		foreach (cmd_seen[i])
			cmd_seen[i] = 0;
		for (int i = 0; i < SLOTS; i++) begin
			shadow_xmin_ep[i] = '0;
			shadow_xmax_ep[i] = '0;
			shadow_flags[i] = '0;
		end
		shadow_high_water = 0;
		shadow_default_epoch = '0;

		// every input known from time zero
		arst_n <= 1'b0;
		start <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		command <= CMD_CLEAR;
		slot_number <= '0;
		xmin_epoch_in <= '0;
		xmax_epoch_in <= '0;
		flags_in <= '0;
		whole_reset <= 1'b0;
		raw_xmin <= '0;
		raw_xmax <= '0;
		xmin_frozen <= 1'b0;
		xmax_invalid <= 1'b0;
		xmax_multi <= 1'b0;
		materialized <= 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; mode fields read zero on anything but interpret
		// empty page, default epoch still at its reset value: implicit on both sides
		dir_rows.push_back('{mk_word(CMD_INTERP, 1, 0, 0, 0, 0, 5, 7, 0, 0, 0, 1), 1,
			mk_res(64'd5, 64'd7, XMIN_IMPLICIT, XMAX_IMPLICIT, 0, 0)});
		// writes to slot zero, just past the end, the top code, all refused
		dir_rows.push_back('{mk_word(CMD_INSERT, 0, 32'h1234_5678, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, mk_res(0, 0, XMIN_MAT, XMAX_MAT, 1, 0)});
		dir_rows.push_back('{mk_word(CMD_INSERT, SLOTS + 1, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, mk_res(0, 0, XMIN_MAT, XMAX_MAT, 1, 0)});
		dir_rows.push_back('{mk_word(CMD_SET_XMAX, '1, 0, '1, 0, 0, 0, 0, 0, 0, 0, 0),
			1, mk_res(0, 0, XMIN_MAT, XMAX_MAT, 1, 0)});
		dir_rows.push_back('{mk_word(CMD_REDO, 0, '1, '1, 3, 1, 0, 0, 0, 0, 0, 0),
			1, mk_res(0, 0, XMIN_MAT, XMAX_MAT, 1, 0)});
		// first slot with all-ones epochs
		dir_rows.push_back('{mk_word(CMD_INSERT, 1, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, mk_res(0, 0, XMIN_MAT, XMAX_MAT, 0, 1)});
		dir_rows.push_back('{mk_word(CMD_SET_XMAX, 1, 0, '1, 0, 0, 0, 0, 0, 0, 0, 0),
			1, mk_res(0, 0, XMIN_MAT, XMAX_MAT, 0, 1)});
		dir_rows.push_back('{mk_word(CMD_INTERP, 1, 0, 0, 0, 0, '1, '1, 0, 0, 0, 1),
			1, mk_res('1, '1, XMIN_MAT, XMAX_MAT, 0, 1)});
		// last slot lifts the high-water mark to its top
		dir_rows.push_back('{mk_word(CMD_INSERT, SLOTS, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, mk_res(0, 0, XMIN_MAT, XMAX_MAT, 0, SLOTS)});
		// not materialized: slot ignored
		dir_rows.push_back('{mk_word(CMD_INTERP, SLOTS, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0),
			1, mk_res(64'd1, 64'd1, XMIN_IMPLICIT, XMAX_IMPLICIT, 0, SLOTS)});
		// frozen beats invalid xmin, invalid flag beats multixact
		dir_rows.push_back('{mk_word(CMD_INTERP, SLOTS, 0, 0, 0, 0, 0, '1, 1, 1, 1, 1),
			1, mk_res(64'd2, 0, XMIN_FROZEN, XMAX_UNSET, 0, SLOTS)});
		// raw zero xmin, multixact xmax
		dir_rows.push_back('{mk_word(CMD_INTERP, SLOTS, 0, 0, 0, 0, 0, 5, 0, 0, 1, 1),
			1, mk_res(0, 0, XMIN_INVALID, XMAX_MULTI, 0, SLOTS)});
		// materialized xmin, raw zero xmax
		dir_rows.push_back('{mk_word(CMD_INTERP, SLOTS, 0, 0, 0, 0, 3, 0, 0, 0, 0, 1),
			1, mk_res({32'h8000_0000, 32'd3}, 0, XMIN_MAT, XMAX_INVALID, 0, SLOTS)});
		// out-of-range reads fall back to the default
		dir_rows.push_back('{mk_word(CMD_INTERP, 0, 0, 0, 0, 0, 9, 9, 0, 0, 0, 1), 0, none});
		dir_rows.push_back('{mk_word(CMD_INTERP, '1, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0001,
			0, 0, 0, 1), 0, none});
		// redo: whole rewrite with xmax only, then merges
		dir_rows.push_back('{mk_word(CMD_REDO, 5, 32'hA5A5_0001, 32'h5A5A_0002, 2, 1,
			0, 0, 0, 0, 0, 0), 0, none});
		dir_rows.push_back('{mk_word(CMD_INTERP, 5, 0, 0, 0, 0, 11, 12, 0, 0, 0, 1), 0, none});
		dir_rows.push_back('{mk_word(CMD_REDO, 5, 32'h0000_0003, 32'hFFFF_0000, 1, 0,
			0, 0, 0, 0, 0, 0), 0, none});
		dir_rows.push_back('{mk_word(CMD_INTERP, 5, 0, 0, 0, 0, 13, 14, 0, 0, 0, 1), 0, none});
		dir_rows.push_back('{mk_word(CMD_REDO, 6, '1, '1, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
		dir_rows.push_back('{mk_word(CMD_REDO, 300, '1, '1, 3, 1, 0, 0, 0, 0, 0, 0),
			1, mk_res(0, 0, XMIN_MAT, XMAX_MAT, 1, SLOTS)});
		// spare codes do nothing
		dir_rows.push_back('{mk_word(CMD_SPARE_LO, 1, '1, '1, 3, 1, '1, '1, 1, 1, 1, 1),
			1, mk_res(0, 0, XMIN_MAT, XMAX_MAT, 0, SLOTS)});
		dir_rows.push_back('{mk_word(CMD_SPARE_HI, 2, '1, '1, 3, 0, '1, '1, 1, 1, 1, 1),
			1, mk_res(0, 0, XMIN_MAT, XMAX_MAT, 0, SLOTS)});
		// clear empties the page
		dir_rows.push_back('{mk_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, mk_res(0, 0, XMIN_MAT, XMAX_MAT, 0, 0)});
		dir_rows.push_back('{mk_word(CMD_INTERP, 1, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1),
			1, mk_res(64'd1, 64'd1, XMIN_IMPLICIT, XMAX_IMPLICIT, 0, 0)});
		// read just past the high-water mark
		dir_rows.push_back('{mk_word(CMD_INSERT, 3, 32'h0000_0042, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			0, none});
		dir_rows.push_back('{mk_word(CMD_INTERP, 4, 0, 0, 0, 0, 21, 22, 0, 0, 0, 1), 0, none});

		// reset value written back explicitly before the directed rows
		write_default_epoch('0);
		idle_pct = 20;
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
			sender_gap();
		end

		// each phase starts drained with a new default epoch: top, random, mid
		phase_epoch[0] = '1;
		phase_epoch[1] = $urandom;
		phase_epoch[2] = 32'h8000_0000;
		for (int ph = 0; ph < 3; ph++) begin
			write_default_epoch(phase_epoch[ph]);
			idle_pct = (ph == 0) ? 11 : (ph == 1) ? 65 : 0;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				send_word(rand_word(), 0, none);
				sender_gap();
			end
		end
		start <= 1'b0;

		// drain, then a few cycles for any stray done
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d words: clear %0d insert %0d set-xmax %0d redo %0d interpret %0d",
			words_sent, cmd_seen[CMD_CLEAR], cmd_seen[CMD_INSERT], cmd_seen[CMD_SET_XMAX],
			cmd_seen[CMD_REDO], cmd_seen[CMD_INTERP]);
		$display("spare %0d, range errors %0d, slot reads %0d, default epochs %0d, checked %0d",
			cmd_seen[CMD_SPARE_LO] + cmd_seen[CMD_SPARE_MID] + cmd_seen[CMD_SPARE_HI],
			range_errs_seen, slot_hits, epoch_settings, results_checked);
		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("mismatches %0d, results still owed %0d", mismatches, owed_results.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
